[rtl/pru_pkg.sv]
// Package: payload types and constants of the page replacement unit.
package pru_pkg;

  localparam int MaxFrames = 64;
  localparam int PageW = 20;
  localparam int PageLsb = 12;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_CLOCK = 2'd1;
  localparam logic [1:0] POL_LRU = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  typedef struct packed {
    logic [31:0] address;
    logic        is_write;
  } pru_in_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  frame_index;
    logic        evicted;
    logic [19:0] evicted_page;
    logic        wrote_back;
    logic [31:0] access_total;
    logic [31:0] miss_total;
    logic [31:0] write_total;
    logic [31:0] drop_total;
  } pru_out_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hffff_ffff) ? v : v + 32'd1;
  endfunction

endpackage

[rtl/page_replacement_unit.sv]
// Top level: page replacement unit with a one-frame-per-cycle scan sequencer.
//
// Input channel in_valid/in_ready/in_data takes one access (address, is_write).
// Result channel out_valid/out_ready/out_data returns one result per access.
// The configuration port (APB style, cfg_ prefix) holds policy at 0x0 and
// frames_in_use at 0x4; write it only while the block is idle.
// An access scans the filled frames for a tag match, one frame a cycle through
// a single compare unit. A hit ends the scan at the matching frame; a miss then
// fills a free frame or evicts by FIFO, a CLOCK eviction walks on from the hand
// and clears s (at most n) used frames on the way, and an LRU eviction walks
// all n frames. in_ready is high only when idle, so one access at a time.
// The result sits in an output register; while the receiver stalls the block
// holds it and takes no new access. Reset clears all control state, counters
// and used/dirty bits; the page and last-use stores need no clearing, as only
// frames that have been filled are ever read.
module page_replacement_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pru_pkg::pru_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pru_pkg::pru_out_t  out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import pru_pkg::*;

  localparam int IW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int CW = $clog2(MaxFrames + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MISS = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_UPD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_r;
  logic [1:0] policy_r;
  logic [6:0] frames_r;
  logic [PageW-1:0] page_mem [MaxFrames];
  logic [MaxFrames-1:0] dirty_r, used_r;
  logic [31:0] last_use_r [MaxFrames];
  logic [CW-1:0] filled_r, idx_r, n_c, steps_r;
  logic [IW-1:0] fifo_r, hand_r, frame_r, best_r;
  logic [31:0] best_t_r, time_r, acc_r, miss_r, wr_r, drop_r, lu_rd_r;
  logic [PageW-1:0] page_r, rd_page_r, ev_page_r;
  logic write_r, hit_r, ev_r, wb_r;
  pru_out_t out_r;
  logic [IW-1:0] idx_i, rd_addr, lu_addr;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAMES) ? {25'd0, frames_r} : {30'd0, policy_r};
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = out_r;

  always_comb begin
    if (frames_r == 7'd0) n_c = CW'(1);
    else if (32'(frames_r) > MaxFrames) n_c = CW'(MaxFrames);
    else n_c = CW'(frames_r);
  end
  assign idx_i = idx_r[IW-1:0];
  // Fetch one frame ahead of the compare so the stored data arrives registered
  assign rd_addr = (state_r == S_LOOK) ? idx_i + IW'(1) : '0;
  assign lu_addr = (state_r == S_SWEEP) ? idx_i + IW'(1) : '0;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] h, input logic [CW-1:0] n);
    wrap_inc = (CW'(h) + CW'(1) < n) ? h + IW'(1) : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == S_UPD && !hit_r) page_mem[frame_r] <= page_r;
    rd_page_r <= page_mem[rd_addr];
    if (state_r == S_UPD) ev_page_r <= ev_r ? page_mem[frame_r] : '0;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) last_use_r[frame_r] <= time_r + 32'd1;
    lu_rd_r <= last_use_r[lu_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; policy_r <= POL_FIFO; frames_r <= 7'd64;
      dirty_r <= '0; used_r <= '0; filled_r <= '0; fifo_r <= '0; hand_r <= '0;
      time_r <= '0; acc_r <= '0; miss_r <= '0; wr_r <= '0; drop_r <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_POLICY) policy_r <= cfg_pwdata[1:0];
        else frames_r <= cfg_pwdata[6:0];
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          page_r <= in_data.address[31:PageLsb];
          write_r <= in_data.is_write;
          acc_r <= sat_inc(acc_r);
          idx_r <= '0; hit_r <= 1'b0; ev_r <= 1'b0; wb_r <= 1'b0;
          state_r <= S_LOOK;
        end
        S_LOOK: begin
          if (idx_r >= filled_r) state_r <= S_MISS;
          else if (rd_page_r == page_r) begin
            hit_r <= 1'b1; frame_r <= idx_i; state_r <= S_UPD;
          end else idx_r <= idx_r + CW'(1);
        end
        S_MISS: begin
          miss_r <= sat_inc(miss_r);
          if (filled_r < n_c) begin
            frame_r <= filled_r[IW-1:0]; filled_r <= filled_r + CW'(1);
            state_r <= S_UPD;
          end else begin
            ev_r <= 1'b1;
            if (policy_r == POL_CLOCK) begin
              idx_r <= (CW'(hand_r) < n_c) ? CW'(hand_r) : '0;
              steps_r <= '0; state_r <= S_SWEEP;
            end else if (policy_r == POL_LRU) begin
              // frame 0 always beats the ceiling, so the walk starts there
              idx_r <= '0; best_r <= '0; best_t_r <= 32'hffff_ffff;
              state_r <= S_SWEEP;
            end else begin
              frame_r <= (CW'(fifo_r) < n_c) ? fifo_r : '0;
              fifo_r <= wrap_inc((CW'(fifo_r) < n_c) ? fifo_r : '0, n_c);
              state_r <= S_UPD;
            end
          end
        end
        S_SWEEP: begin
          if (policy_r == POL_CLOCK) begin
            if (!used_r[idx_i] || (steps_r > n_c)) begin
              frame_r <= idx_i; hand_r <= wrap_inc(idx_i, n_c); state_r <= S_UPD;
            end else begin
              used_r[idx_i] <= 1'b0; idx_r <= CW'(wrap_inc(idx_i, n_c));
              steps_r <= steps_r + CW'(1);
            end
          end else begin
            if (idx_r >= n_c) begin
              frame_r <= best_r; state_r <= S_UPD;
            end else begin
              if (lu_rd_r <= best_t_r) begin
                best_r <= idx_i; best_t_r <= lu_rd_r;
              end
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        S_UPD: begin
          if (ev_r) begin
            wb_r <= dirty_r[frame_r];
            if (dirty_r[frame_r]) wr_r <= sat_inc(wr_r);
            else drop_r <= sat_inc(drop_r);
          end
          dirty_r[frame_r] <= write_r | (hit_r & dirty_r[frame_r]);
          used_r[frame_r] <= 1'b1;
          time_r <= time_r + 32'd1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_r.hit = hit_r;
    out_r.frame_index = 6'(frame_r);
    out_r.evicted = ev_r;
    out_r.evicted_page = ev_page_r;
    out_r.wrote_back = wb_r;
    out_r.access_total = acc_r;
    out_r.miss_total = miss_r;
    out_r.write_total = wr_r;
    out_r.drop_total = drop_r;
  end
endmodule

[tb/testbench.sv]
// Testbench for the page replacement unit: directed and random accesses checked by a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pru_pkg::*;

  localparam int Frames = 64;
  localparam int SettleCycles = 200;
  localparam logic [1:0] POL_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pru_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pru_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  page_replacement_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Mirror of the block's state
  logic [1:0]  mdl_policy = POL_FIFO;
  logic [6:0]  mdl_frames = 7'd64;
  logic [19:0] mdl_page [Frames];
  bit          mdl_dirty [Frames];
  bit          mdl_used [Frames];
  logic [31:0] mdl_last [Frames];
  int          mdl_filled;
  int          mdl_fifo_next;
  int          mdl_hand;
  logic [31:0] mdl_time;
  logic [31:0] mdl_acc, mdl_miss, mdl_wb, mdl_drop;

  pru_out_t pending_results [$];
  int  failures = 0;
  int  accesses_sent = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  evictions_seen = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  logic [19:0] page_pool [128];

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hffff_ffff) ? v : v + 32'd1;
  endfunction

  function automatic pru_out_t predict_access(logic [31:0] addr, logic wr);
    pru_out_t r;
    logic [19:0] pg;
    int n, fr, h;
    bit found;
    r = '0;
    found = 0;
    fr = 0;
    n = (mdl_frames == 0) ? 1 : (mdl_frames > Frames) ? Frames : int'(mdl_frames);
    pg = addr[31:12];
    mdl_acc = bump(mdl_acc);
    for (int i = 0; i < mdl_filled; i++) begin
      if (!found && mdl_page[i] == pg) begin
        found = 1;
        fr = i;
      end
    end
    if (!found) begin
      mdl_miss = bump(mdl_miss);
      if (mdl_filled < n) begin
        fr = mdl_filled;
        mdl_filled++;
      end else begin
        case (mdl_policy)
          POL_CLOCK: begin
            h = (mdl_hand < n) ? mdl_hand : 0;
            for (int s = 0; s <= n; s++) begin
              if (!mdl_used[h]) break;
              mdl_used[h] = 0;
              h = (h + 1 < n) ? h + 1 : 0;
            end
            mdl_hand = (h + 1 < n) ? h + 1 : 0;
            fr = h;
          end
          POL_LRU: begin
            fr = 0;
            for (int i = 1; i < n; i++)
              if (mdl_last[i] <= mdl_last[fr]) fr = i;
          end
          default: begin
            fr = (mdl_fifo_next < n) ? mdl_fifo_next : 0;
            mdl_fifo_next = (fr + 1 < n) ? fr + 1 : 0;
          end
        endcase
        r.evicted = 1'b1;
        r.evicted_page = mdl_page[fr];
        r.wrote_back = mdl_dirty[fr];
        if (mdl_dirty[fr]) mdl_wb = bump(mdl_wb);
        else mdl_drop = bump(mdl_drop);
      end
      mdl_page[fr] = pg;
      mdl_dirty[fr] = 0;
    end
    if (wr) mdl_dirty[fr] = 1;
    mdl_used[fr] = 1;
    mdl_time = mdl_time + 32'd1;
    mdl_last[fr] = mdl_time;
    r.hit = found;
    r.frame_index = fr[5:0];
    r.access_total = mdl_acc;
    r.miss_total = mdl_miss;
    r.write_total = mdl_wb;
    r.drop_total = mdl_drop;
    return r;
  endfunction

  // Offer one access; valid stays high afterwards unless the next caller lowers it
  task automatic send_access(logic [31:0] addr, logic wr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{address: addr, is_write: wr};
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_access(addr, wr));
    accesses_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_idx, logic [31:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == REG_POLICY) mdl_policy = value[1:0];
    else mdl_frames = value[6:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 76; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 76; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  function automatic logic [31:0] page_addr(logic [19:0] pg);
    return {pg, 12'($urandom_range(0, 4095))};
  endfunction

  task automatic test_directed();
    set_idling(0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hffff_ffff, 1'b1);
    send_access(32'h0000_0fff, 1'b1);          // same page as address zero: hit
    send_access(32'hffff_f000, 1'b0);
    send_access(32'h0000_3000, 1'b0);
    send_access(32'h8000_1000, 1'b1);
    send_access(32'h5555_5555, 1'b0);
    send_access(32'haaaa_aaaa, 1'b1);
    // shrink below the filled count: upper frames still hit, victims from frame 0 only
    write_reg(REG_FRAMES, 32'd1);
    send_access(32'haaaa_a000, 1'b0);
    send_access(32'h1234_5000, 1'b0);
    send_access(32'h0000_0000, 1'b1);
    // zero frames acts as one
    write_reg(REG_FRAMES, 32'd0);
    send_access(32'h7777_7000, 1'b0);
    // grow again: fill continues past the old count
    write_reg(REG_FRAMES, 32'd10);
    send_access(32'h0101_0000, 1'b1);
    send_access(32'h0202_0000, 1'b0);
    send_access(32'h0303_0000, 1'b0);
    send_access(32'h0404_0000, 1'b1);
    write_reg(REG_POLICY, {30'd0, POL_CLOCK});
    write_reg(REG_FRAMES, 32'd3);
    send_access(32'h0505_0000, 1'b0);
    send_access(32'h0606_0000, 1'b1);
    write_reg(REG_POLICY, {30'd0, POL_LRU});
    send_access(32'h0000_1000, 1'b0);
    send_access(32'h0707_0000, 1'b0);
    write_reg(REG_POLICY, {30'd0, POL_SPARE});  // spare code behaves as FIFO
    write_reg(REG_FRAMES, 32'd127);             // above the maximum: clipped
    send_access(32'h0808_0000, 1'b1);
    send_access(32'h0909_0000, 1'b0);
  endtask

  task automatic run_phase(logic [1:0] pol, int frames, int count, int mode);
    int n, pool_size;
    logic [19:0] pg;
    write_reg(REG_POLICY, {30'd0, pol});
    write_reg(REG_FRAMES, 32'(frames));
    set_idling(mode);
    n = (frames == 0) ? 1 : (frames > Frames) ? Frames : frames;
    pool_size = (n + n / 2 + 2 > 128) ? 128 : n + n / 2 + 2;
    foreach (page_pool[i]) page_pool[i] = 20'($urandom);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 88) pg = page_pool[$urandom_range(0, pool_size - 1)];
      else pg = 20'($urandom);
      send_access(page_addr(pg), 1'($urandom));
    end
  endtask

  task automatic test_random();
    run_phase(POL_FIFO, 1, 60, 0);
    run_phase(POL_CLOCK, 4, 100, 1);
    run_phase(POL_LRU, 8, 100, 2);
    run_phase(POL_SPARE, 16, 90, 3);
    run_phase(POL_CLOCK, 64, 90, 0);
    run_phase(POL_LRU, 64, 80, 3);
    run_phase(POL_FIFO, 0, 40, 2);
    run_phase(POL_CLOCK, 100, 60, 2);
    run_phase(POL_LRU, 3, 90, 1);
    run_phase(POL_FIFO, 7, 80, 0);
  endtask

  task automatic test_backpressure();
    write_reg(REG_POLICY, {30'd0, POL_CLOCK});
    write_reg(REG_FRAMES, 32'd5);
    set_idling(0);
    hold_requests++;
    for (int k = 0; k < 40; k++)
      send_access(page_addr(20'($urandom_range(0, 7))), 1'($urandom));
  endtask

  // Result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served && hold_left == 0) begin
      hold_served <= hold_served + 1;
      hold_left <= 2000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    pru_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_data.hit));
        check_field("frame_index", 32'(want.frame_index), 32'(out_data.frame_index));
        check_field("evicted", 32'(want.evicted), 32'(out_data.evicted));
        check_field("evicted_page", 32'(want.evicted_page), 32'(out_data.evicted_page));
        check_field("wrote_back", 32'(want.wrote_back), 32'(out_data.wrote_back));
        check_field("access_total", want.access_total, out_data.access_total);
        check_field("miss_total", want.miss_total, out_data.miss_total);
        check_field("write_total", want.write_total, out_data.write_total);
        check_field("drop_total", want.drop_total, out_data.drop_total);
        results_seen++;
        if (out_data.hit) hits_seen++;
        if (out_data.evicted) evictions_seen++;
      end
    end
  end

  initial begin
    #20ms;
    $display("page_replacement_unit: mismatch");
    $finish;
  end

  initial begin
    foreach (mdl_page[i]) begin
      mdl_page[i] = '0;
      mdl_dirty[i] = 0;
      mdl_used[i] = 0;
      mdl_last[i] = '0;
    end
    mdl_filled = 0;
    mdl_fifo_next = 0;
    mdl_hand = 0;
    mdl_time = '0;
    mdl_acc = '0;
    mdl_miss = '0;
    mdl_wb = '0;
    mdl_drop = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    $display("Covered %0d accesses over FIFO, CLOCK, LRU and the spare policy code.",
             accesses_sent);
    $display("Checked %0d results: %0d hits, %0d evictions.", results_seen, hits_seen,
             evictions_seen);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("page_replacement_unit: match");
    end else begin
      $display("page_replacement_unit: mismatch");
    end
    $finish;
  end

endmodule
